// File: src/ptk_pkg.sv
`default_nettype none

package ptk_pkg;

  // List geometry
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned NUM_QUERIES = 8;
  localparam int unsigned DOC_BITS    = 20;

  // Fixed field widths
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned QIDX_W  = 3;
  localparam int unsigned RANK_W  = 4;
  localparam int unsigned LCNT_W  = 5;

  // Derived widths
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned QADDR_W = (NUM_QUERIES > 1) ? $clog2(NUM_QUERIES) : 1;

  // Front queue, power of two deep
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FPTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_READ,
    KIND_NULL
  } kind_e;

  typedef struct packed {
    logic [SCORE_W-1:0]  score;
    logic [DOC_BITS-1:0] doc;
  } entry_t;

  typedef entry_t [DEPTH-1:0] row_t;

  // Classified word handed from front to back
  typedef struct packed {
    kind_e               kind;
    logic [QIDX_W-1:0]   query;
    logic [DOC_BITS-1:0] doc;
    logic [SCORE_W-1:0]  score;
    logic [RANK_W-1:0]   rank;
  } item_t;

  typedef struct packed {
    logic                      accepted;
    logic [RANK_W-1:0]         placed_rank;
    logic                      evicted_valid;
    logic [DOC_BITS-1:0]       evicted_doc;
    logic                      entry_valid;
    logic [DOC_BITS-1:0]       entry_doc;
    logic signed [SCORE_W-1:0] entry_score;
    logic [LCNT_W-1:0]         list_count;
  } rsp_t;

endpackage

`default_nettype wire

// File: src/ptk_req_if.sv
`default_nettype none

interface ptk_req_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [ptk_pkg::QIDX_W-1:0]         query_index;
  logic [ptk_pkg::DOC_BITS-1:0]       doc_id;
  logic signed [ptk_pkg::SCORE_W-1:0] cand_score;
  logic [ptk_pkg::RANK_W-1:0]         read_rank;

  modport source (
    output valid, opcode, query_index, doc_id, cand_score, read_rank,
    input  ready
  );

  modport sink (
    input  valid, opcode, query_index, doc_id, cand_score, read_rank,
    output ready
  );
endinterface

`default_nettype wire

// File: src/ptk_rsp_if.sv
`default_nettype none

interface ptk_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               accepted;
  logic [ptk_pkg::RANK_W-1:0]         placed_rank;
  logic                               evicted_valid;
  logic [ptk_pkg::DOC_BITS-1:0]       evicted_doc;
  logic                               entry_valid;
  logic [ptk_pkg::DOC_BITS-1:0]       entry_doc;
  logic signed [ptk_pkg::SCORE_W-1:0] entry_score;
  logic [ptk_pkg::LCNT_W-1:0]         list_count;

  modport source (
    output valid, accepted, placed_rank, evicted_valid, evicted_doc,
           entry_valid, entry_doc, entry_score, list_count,
    input  ready
  );

  modport sink (
    input  valid, accepted, placed_rank, evicted_valid, evicted_doc,
           entry_valid, entry_doc, entry_score, list_count,
    output ready
  );
endinterface

`default_nettype wire

// File: src/ptk_front.sv
`default_nettype none

module ptk_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ptk_req_if.sink        req_i,
  output logic           item_valid_o,
  output ptk_pkg::item_t item_o,
  input  logic           item_ready_i
);
  import ptk_pkg::*;

  item_t             fifo_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0] cnt_q;
  item_t             new_item;
  logic              push, pop;

  assign req_i.ready  = (cnt_q != FCNT_W'(FIFO_DEPTH));
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = fifo_q[rd_ptr_q];

  // Classify the incoming word
  always_comb begin
    new_item.query = req_i.query_index;
    new_item.doc   = req_i.doc_id;
    new_item.score = req_i.cand_score;
    new_item.rank  = req_i.read_rank;
    if (int'(req_i.query_index) >= int'(NUM_QUERIES)) begin
      new_item.kind = KIND_NULL;
    end else if (req_i.opcode == OP_READ) begin
      new_item.kind = KIND_READ;
    end else begin
      new_item.kind = KIND_INSERT;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_item;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/ptk_back.sv
`default_nettype none

module ptk_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  ptk_pkg::item_t item_i,
  output logic           item_ready_o,
  ptk_rsp_if.source      rsp_o
);
  import ptk_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e             state_q;
  item_t              cur_q;
  row_t               row_q;
  row_t               mem_q [NUM_QUERIES];
  logic [CNT_W-1:0]   held_q [NUM_QUERIES];
  logic               out_valid_q;
  rsp_t               out_q;

  logic               pop, fire;
  logic [QADDR_W-1:0] qaddr;
  logic [CNT_W-1:0]   cnt, cnt_eff, cnt_new, pos;
  logic               full, beats, take, hit;
  entry_t             worst, cand, sel;
  logic [DEPTH-1:0]   le;
  row_t               new_row;
  rsp_t               rsp_d;

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = (state_q == ST_IDLE) && item_valid_i;
  assign fire         = (state_q == ST_EXEC) && (!out_valid_q || rsp_o.ready);
  assign qaddr        = QADDR_W'(cur_q.query);

  // Row memory: one wide row per query, registered read
  always_ff @(posedge clk_i) begin
    if (pop) begin
      row_q <= mem_q[QADDR_W'(item_i.query)];
    end
    if (fire && take) begin
      mem_q[qaddr] <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= item_i;
    end
  end

  // Held counts per query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_QUERIES); i++) begin
        held_q[i] <= '0;
      end
    end else if (fire && take) begin
      held_q[qaddr] <= cnt_new;
    end
  end

  // Parallel compare against the whole row, shift and insert
  always_comb begin
    cnt     = held_q[qaddr];
    full    = (cnt == CNT_W'(DEPTH));
    worst   = row_q[DEPTH-1];
    beats   = $signed(cur_q.score) < $signed(worst.score);
    cnt_eff = full ? CNT_W'(DEPTH - 1) : cnt;
    take    = (cur_q.kind == KIND_INSERT) && (!full || beats);
    cnt_new = cnt_eff + 1'b1;
    cand.score = cur_q.score;
    cand.doc   = cur_q.doc;

    // le is a thermometer: ranks holding a score at or below the candidate
    for (int i = 0; i < int'(DEPTH); i++) begin
      le[i] = (CNT_W'(i) < cnt_eff) &&
              ($signed(row_q[i].score) <= $signed(cur_q.score));
    end

    pos = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      if (le[i]) pos = CNT_W'(i + 1);
    end

    new_row[0] = le[0] ? row_q[0] : cand;
    for (int i = 1; i < int'(DEPTH); i++) begin
      if (le[i]) begin
        new_row[i] = row_q[i];
      end else if (le[i-1]) begin
        new_row[i] = cand;
      end else begin
        new_row[i] = row_q[i-1];
      end
    end

    // Read select
    sel = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      if (int'(cur_q.rank) == i) sel = row_q[i];
    end
    hit = int'(cur_q.rank) < int'(cnt);
  end

  // Result word
  always_comb begin
    rsp_d = '0;
    case (cur_q.kind)
      KIND_INSERT: begin
        rsp_d.list_count = LCNT_W'(cnt);
        if (take) begin
          rsp_d.accepted      = 1'b1;
          rsp_d.placed_rank   = RANK_W'(pos);
          rsp_d.evicted_valid = full;
          rsp_d.evicted_doc   = full ? worst.doc : '0;
          rsp_d.list_count    = LCNT_W'(cnt_new);
        end
      end
      KIND_READ: begin
        rsp_d.list_count = LCNT_W'(cnt);
        if (hit) begin
          rsp_d.entry_valid = 1'b1;
          rsp_d.entry_doc   = sel.doc;
          rsp_d.entry_score = $signed(sel.score);
        end
      end
      default: rsp_d = '0;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: if (pop)  state_q <= ST_EXEC;
        ST_EXEC: if (fire) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
      if (fire) begin
        out_valid_q <= 1'b1;
        out_q       <= rsp_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.accepted      = out_q.accepted;
  assign rsp_o.placed_rank   = out_q.placed_rank;
  assign rsp_o.evicted_valid = out_q.evicted_valid;
  assign rsp_o.evicted_doc   = out_q.evicted_doc;
  assign rsp_o.entry_valid   = out_q.entry_valid;
  assign rsp_o.entry_doc     = out_q.entry_doc;
  assign rsp_o.entry_score   = out_q.entry_score;
  assign rsp_o.list_count    = out_q.list_count;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> (cnt <= CNT_W'(DEPTH)))
    else $error("held count above list depth");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.evicted_valid) |->
      (out_q.accepted && (out_q.list_count == LCNT_W'(DEPTH))))
    else $error("eviction without a full list");

  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished word not presented");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EXEC) && !fire) |=> ((state_q == ST_EXEC) && $stable(row_q)))
    else $error("row lost during output stall");

endmodule

`default_nettype wire

// File: src/per_query_top_k_keeper.sv
`default_nettype none

// Sorted top list keeper: holds up to DEPTH (document, score) pairs per query,
// lowest score first, with ties placed after existing equals. Each request
// word is taken into a two-word front queue and classified; the back end then
// handles one word at a time: it first reads the query's whole row from the
// row memory into a register, then compares every rank in parallel, shifts,
// writes the row back and loads the result register once that register is
// empty or being read; only then does it take the next word. A waiting
// result does not block acceptance until the front queue fills. Counts
// clear on reset; no memory clearing pass is needed.
module per_query_top_k_keeper (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptk_req_if.sink   req_i,
  ptk_rsp_if.source rsp_o
);
  import ptk_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_ready;

  ptk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  ptk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire
